// ===== design/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg: shared definitions for the Huffman code bit packer
// Item operation codes, field widths, table sizing and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

  // Table sizing.
  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int ADDR_W       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  // Field widths of an input item.
  localparam int OP_W   = 2;
  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;

  // Longest code the packer stores; longer lengths saturate to it.
  localparam int CODE_CAP = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // One table row holds the length above the code bits.
  localparam int ROW_W = CODE_W + LEN_W;

  // Stream widths (fields packed from the lowest bit, padded to bytes).
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;
  localparam int OUT_USER_W = 2;

  // Operation carried in the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  // One result item.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic [2:0] pad_bits;
    logic       unknown_symbol;
    logic       last;
  } result_t;

endpackage

`default_nettype wire

// ===== design/hcbp_ram.sv =====
// ----------------------------------------------------------------------------
// hcbp_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_ram #(
  parameter int Width = 38,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Storage array and registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== design/huffman_code_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_unit: table-driven Huffman encoder and byte packer
// Loads a code table, encodes symbols into a bit stream and emits bytes.
// ----------------------------------------------------------------------------
// A write item stores a symbol's code and length in the code RAM at once and
// gives no result. An encode item reads the RAM in the cycle it is accepted;
// when the lookup stage hands it on, its code is merged with the held bits
// and each completed byte leaves through the output register, one per cycle
// while the output is not stalled, earliest bit in bit 7, the final one
// marked with tlast. The packer takes no new item until every completed byte
// of the previous encode item has gone to the output register. Input items
// are accepted back to back while the packer keeps up; one item can wait in
// the lookup stage while the output is stalled.
// Entry valid flags are flip-flops cleared by reset, so no clearing pass is
// needed; entries never written are reported as unknown symbols.
`default_nettype none

module huffman_code_bit_packer_unit
  import hcbp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Input items.
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // symbol, code_value, code_length
  input  wire logic [OP_W-1:0]       s_axis_tuser_i,   // op
  // Result items.
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,   // out_byte, pad_bits
  output logic [OUT_USER_W-1:0]      m_axis_tuser_o,   // byte_valid, unknown_symbol
  output logic                       m_axis_tlast_o
);

  // Input field unpacking.
  op_e               in_op;
  logic [SYM_W-1:0]  in_sym;
  logic [CODE_W-1:0] in_code;
  logic [LEN_W-1:0]  in_len;
  logic [LEN_W-1:0]  in_len_sat;
  logic [ADDR_W-1:0] in_addr;
  logic              in_range;
  logic              in_accept;

  assign in_op    = op_e'(s_axis_tuser_i);
  assign in_sym   = s_axis_tdata_i[SYM_W-1:0];
  assign in_code  = s_axis_tdata_i[SYM_W+CODE_W-1:SYM_W];
  assign in_len   = s_axis_tdata_i[SYM_W+CODE_W+LEN_W-1:SYM_W+CODE_W];
  assign in_addr  = in_sym[ADDR_W-1:0];
  assign in_range = ({1'b0, in_sym} < (SYM_W+1)'(SYMBOL_COUNT));
  assign in_len_sat = (in_len > LEN_W'(CODE_CAP)) ? LEN_W'(CODE_CAP) : in_len;

  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;

  // Table write and lookup controls.
  logic tbl_we;
  logic tbl_re;
  logic s1_load;

  assign tbl_we  = in_accept && (in_op == OP_WRITE) && in_range;
  assign tbl_re  = in_accept && (in_op == OP_ENCODE);
  assign s1_load = in_accept && ((in_op == OP_ENCODE) || (in_op == OP_FLUSH));

  // Code table: length above code bits.
  logic [ROW_W-1:0] rd_row;

  hcbp_ram #(
    .Width (ROW_W),
    .Depth (SYMBOL_COUNT)
  ) u_code_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (in_addr),
    .wdata_i ({in_len_sat, in_code}),
    .re_i    (tbl_re),
    .raddr_i (in_addr),
    .rdata_o (rd_row)
  );

  // Entry valid flags, one per table row.
  logic [SYMBOL_COUNT-1:0] valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (tbl_we) begin
      valid_q[in_addr] <= (in_len != '0);
    end
  end

  // Lookup stage: holds an encode or flush item while its row is read.
  logic s1_valid_q, s1_valid_d;
  op_e  s1_op_q;
  logic s1_known_q;
  logic s1_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_op_q    <= in_op;
      s1_known_q <= in_range && valid_q[in_addr];
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (s1_load) begin
      s1_valid_d = 1'b1;
    end else if (s1_take) begin
      s1_valid_d = 1'b0;
    end
  end

  assign s_axis_tready_o = !s1_valid_q || s1_take;

  // Merge the looked-up code with the held bits.
  logic [CODE_W-1:0] rd_code;
  logic [LEN_W-1:0]  rd_len;
  logic [CODE_W:0]   code_mask;
  logic [39:0]       merged;
  logic [LEN_W-1:0]  total;
  logic [2:0]        nbytes;
  logic [2:0]        rem;
  logic [CODE_W-1:0] done_bits;
  logic [CODE_W-1:0] bytes_al;
  logic [7:0]        acc_new;

  // Held state of the packer.
  logic [7:0]        acc_q, acc_d;
  logic [2:0]        held_q, held_d;
  logic [CODE_W-1:0] buf_q, buf_d;
  logic [2:0]        pend_q, pend_d;

  assign rd_code   = rd_row[CODE_W-1:0];
  assign rd_len    = rd_row[ROW_W-1:CODE_W];
  assign code_mask = ((CODE_W+1)'(1) << rd_len) - (CODE_W+1)'(1);
  assign merged    = ({32'b0, acc_q} << rd_len) | {8'b0, rd_code & code_mask[CODE_W-1:0]};
  assign total     = LEN_W'(held_q) + rd_len;
  assign nbytes    = total[5:3];
  assign rem       = total[2:0];
  assign done_bits = CODE_W'(merged >> rem);
  assign bytes_al  = done_bits << (6'd32 - {nbytes, 3'b000});
  assign acc_new   = merged[7:0] & ((8'd1 << rem) - 8'd1);

  // Output register.
  logic    o_valid_q, o_valid_d;
  result_t o_res_q, o_res_d;
  logic    out_ok;
  logic    emit;

  assign out_ok = !o_valid_q || m_axis_tready_i;

  // Packer sequencer: drains pending bytes, then takes the next item.
  always_comb begin
    s1_take = 1'b0;
    emit    = 1'b0;
    o_res_d = '0;
    acc_d   = acc_q;
    held_d  = held_q;
    buf_d   = buf_q;
    pend_d  = pend_q;
    if (out_ok) begin
      if (pend_q != 3'd0) begin
        emit               = 1'b1;
        o_res_d.out_byte   = buf_q[CODE_W-1:CODE_W-8];
        o_res_d.byte_valid = 1'b1;
        o_res_d.last       = (pend_q == 3'd1);
        buf_d              = buf_q << 8;
        pend_d             = pend_q - 3'd1;
      end else if (s1_valid_q) begin
        s1_take = 1'b1;
        unique case (s1_op_q)
          OP_FLUSH: begin
            emit         = 1'b1;
            o_res_d.last = 1'b1;
            if (held_q != 3'd0) begin
              o_res_d.pad_bits   = 3'(4'd8 - {1'b0, held_q});
              o_res_d.out_byte   = 8'(acc_q << o_res_d.pad_bits);
              o_res_d.byte_valid = 1'b1;
            end
            acc_d  = '0;
            held_d = '0;
          end
          OP_ENCODE: begin
            if (!s1_known_q) begin
              emit                   = 1'b1;
              o_res_d.unknown_symbol = 1'b1;
              o_res_d.last           = 1'b1;
            end else begin
              acc_d  = acc_new;
              held_d = rem;
              if (nbytes != 3'd0) begin
                emit               = 1'b1;
                o_res_d.out_byte   = bytes_al[CODE_W-1:CODE_W-8];
                o_res_d.byte_valid = 1'b1;
                o_res_d.last       = (nbytes == 3'd1);
                buf_d              = bytes_al << 8;
                pend_d             = nbytes - 3'd1;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Output valid follows emission and downstream acceptance.
  always_comb begin
    o_valid_d = o_valid_q;
    if (emit) begin
      o_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      o_valid_d = 1'b0;
    end
  end

  // Control and accumulator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q     <= '0;
      held_q    <= '0;
      pend_q    <= '0;
      o_valid_q <= 1'b0;
    end else begin
      acc_q     <= acc_d;
      held_q    <= held_d;
      pend_q    <= pend_d;
      o_valid_q <= o_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    if (emit) begin
      o_res_q <= o_res_d;
    end
  end

  // Output packing.
  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = {5'b0, o_res_q.pad_bits, o_res_q.out_byte};
  assign m_axis_tuser_o  = {o_res_q.unknown_symbol, o_res_q.byte_valid};
  assign m_axis_tlast_o  = o_res_q.last;

  // A code completes at most four bytes, so at most three wait after the first.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pend_q <= 3'd3)
    else $error("pending byte count out of range");

  // No new item enters the packer while bytes of the previous one remain.
  assert property (@(posedge clk_i) disable iff (!rst_ni) (pend_q != 3'd0) |-> !s1_take)
    else $error("item taken while bytes pending");

  // A flush always leaves the accumulator empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_take && (s1_op_q == OP_FLUSH)) |=> (held_q == 3'd0))
    else $error("bits held after flush");

  // The final pending byte is sent marked as last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ok && (pend_q == 3'd1)) |=> (o_valid_q && o_res_q.last))
    else $error("final byte not marked last");

endmodule

`default_nettype wire
